>>> hw/rtl/huffman_tree_table_decoder_defines.svh
// assertion macros for the huffman tree table decoder
// no dependencies; included by files that carry concurrent assertions
`ifndef HUFFMAN_TREE_TABLE_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_TABLE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HUFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hufd assertion failed");
// next-cycle implication
`define HUFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hufd assertion failed");
`else
`define HUFD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HUFD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/hufd_pkg.sv
// shared constants, types and codes for the huffman tree table decoder
// no dependencies
package hufd_pkg;

  // tree sizing
  localparam int MAX_CODE_BITS = 12;
  localparam int SYMBOL_BITS   = 9;
  localparam int TBL_AW        = MAX_CODE_BITS + 1;
  localparam int unsigned TABLE_SIZE = 1 << TBL_AW;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 13;
  localparam int SYM_W    = 9;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  typedef logic [TBL_AW-1:0]      tbl_idx_t;
  typedef logic [TBL_AW:0]        next_idx_t;
  typedef logic [SYMBOL_BITS-1:0] tsym_t;
  typedef logic [SYM_W-1:0]       sym_t;

  typedef struct packed {
    logic  used;
    tsym_t sym;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_DECODE  = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_SYMBOL   = 2'd0,
    STS_END      = 2'd1,
    STS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BITS,
    ST_TAIL,
    ST_FLUSH
  } state_t;

  // register select, paddr bit 2
  localparam logic [0:0] REG_END_SYMBOL = 1'b0;
  localparam logic [0:0] REG_MSB_FIRST  = 1'b1;

  localparam logic [SYM_W-1:0] END_SYMBOL_RST = 9'd256;

endpackage

>>> hw/rtl/hufd_in_if.sv
// input item channel of the huffman tree table decoder
// depends on hufd_pkg
interface hufd_in_if;
  logic                       valid;
  logic                       ready;
  logic [hufd_pkg::CMD_W-1:0]  command;
  logic [hufd_pkg::IDX_W-1:0]  entry_index;
  logic                       entry_used;
  logic [hufd_pkg::SYM_W-1:0]  entry_symbol;
  logic [hufd_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, command, entry_index, entry_used, entry_symbol, data_byte,
                  input ready);
  modport sink   (input valid, command, entry_index, entry_used, entry_symbol, data_byte,
                  output ready);
endinterface

>>> hw/rtl/hufd_out_if.sv
// result item channel of the huffman tree table decoder
// depends on hufd_pkg
interface hufd_out_if;
  logic                         valid;
  logic                         ready;
  logic [hufd_pkg::SYM_W-1:0]    symbol;
  logic [hufd_pkg::STATUS_W-1:0] status;
  logic                         last;

  modport source (output valid, symbol, status, last, input ready);
  modport sink   (input valid, symbol, status, last, output ready);
endinterface

>>> hw/rtl/hufd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module hufd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/huffman_tree_table_decoder.sv
// huffman decoder walking an implicit heap-ordered code tree held in a table ram
// depends on hufd_pkg, hufd_in_if, hufd_out_if, hufd_ram and the defines header
//
//   channel   direction  handshake            carries
//   in_chan   sink       valid/ready          command, entry_index, entry_used,
//                                             entry_symbol, data_byte
//   out_chan  source     valid/ready          symbol, status, last
//   apb       slave      psel/penable/pwrite  end_symbol @0x0, msb_first @0x4
//
// a load, restart or ignored item is finished when it is accepted; a decode byte
// passes through accept, eight code bits, a tail check of the last read and a flush
// of the held item, stopping early on the end symbol or an overflow; the pace is one
// table read per code bit through the single ram read port, whose data is registered
// after reset a clearing pass writes all 8192 table entries with in_chan.ready low;
// apb writes are taken during it
// a stalled out_chan freezes the bit walk only when a second result needs the
// output register, so at most one item waits in the hold stage
`include "huffman_tree_table_decoder_defines.svh"

module huffman_tree_table_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  hufd_in_if.sink                     in_chan,
  hufd_out_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hufd_pkg::APB_AW-1:0] paddr,
  input  logic [hufd_pkg::APB_DW-1:0] pwdata,
  output logic [hufd_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  // configuration registers
  logic [hufd_pkg::SYM_W-1:0] end_symbol_r;
  logic                      msb_first_r;
  logic                      cfg_wr;

  // control state
  hufd_pkg::state_t   state_r, state_nxt;
  hufd_pkg::tbl_idx_t clr_r, clr_nxt;        // clearing pass address
  hufd_pkg::tbl_idx_t walk_r, walk_nxt;      // tree position reached
  logic               pend_r, pend_nxt;      // ram data belongs to walk_r, not yet checked
  logic               done_r, done_nxt;      // end of stream seen
  logic [2:0]         bitcnt_r, bitcnt_nxt;
  logic [hufd_pkg::BYTE_W-1:0] sh_r, sh_nxt; // code bits of the byte, shifted out

  // hold stage: newest result, waits until we know whether it is the last
  logic                hold_valid_r, hold_valid_nxt;
  hufd_pkg::sym_t      hold_sym_r, hold_sym_nxt;
  hufd_pkg::status_t   hold_status_r, hold_status_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  hufd_pkg::sym_t      out_sym_r, out_sym_nxt;
  hufd_pkg::status_t   out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  // table ram
  logic                ram_we;
  hufd_pkg::tbl_idx_t  ram_waddr;
  hufd_pkg::entry_t    ram_wdata;
  logic                ram_re;
  hufd_pkg::entry_t    ram_rdata;

  // walk datapath
  logic                in_fire;
  logic                out_free;
  logic                load_in_range;
  logic                leaf;
  logic                end_match;
  logic                cur_bit;
  hufd_pkg::tbl_idx_t  base_idx;
  hufd_pkg::next_idx_t next_idx;
  logic                overflow;
  logic                new_res;
  hufd_pkg::sym_t      new_sym;
  hufd_pkg::status_t   new_status;
  logic                stall;
  logic                end_take;
  logic                ovf_take;

  hufd_ram #(
    .WIDTH (hufd_pkg::ENTRY_W),
    .DEPTH (hufd_pkg::TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (next_idx[hufd_pkg::TBL_AW-1:0]),
    .rdata (ram_rdata)
  );

  // apb: always ready, register picked by paddr bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_symbol_r <= hufd_pkg::END_SYMBOL_RST;
      msb_first_r  <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[2])
        hufd_pkg::REG_END_SYMBOL: end_symbol_r <= pwdata[hufd_pkg::SYM_W-1:0];
        hufd_pkg::REG_MSB_FIRST:  msb_first_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      hufd_pkg::REG_END_SYMBOL: prdata = hufd_pkg::APB_DW'(end_symbol_r);
      hufd_pkg::REG_MSB_FIRST:  prdata = hufd_pkg::APB_DW'(msb_first_r);
      default:                  prdata = '0;
    endcase
  end

  // handshakes
  assign in_chan.ready   = (state_r == hufd_pkg::ST_IDLE);
  assign in_fire         = in_chan.valid && in_chan.ready;
  assign out_free        = !out_valid_r || out_chan.ready;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.symbol = out_sym_r;
  assign out_chan.status = out_status_r;
  assign out_chan.last   = out_last_r;

  assign load_in_range = (32'(in_chan.entry_index) < 32'(hufd_pkg::TABLE_SIZE));

  // leaf check of the entry read for the previous bit, then the step for this bit
  assign leaf      = pend_r && ram_rdata.used;
  assign end_match = (32'(ram_rdata.sym) == 32'(end_symbol_r));
  assign cur_bit   = msb_first_r ? sh_r[hufd_pkg::BYTE_W-1] : sh_r[0];
  assign base_idx  = leaf ? '0 : walk_r;
  // 2*i+1+bit; a carry out of the table index, or a walk already in the upper
  // half of the table, is the overflow
  assign next_idx  = {base_idx, 1'b1} + hufd_pkg::next_idx_t'(cur_bit);
  assign overflow  = next_idx[hufd_pkg::TBL_AW] || base_idx[hufd_pkg::TBL_AW-1];

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    walk_nxt        = walk_r;
    pend_nxt        = pend_r;
    done_nxt        = done_r;
    bitcnt_nxt      = bitcnt_r;
    sh_nxt          = sh_r;
    hold_valid_nxt  = hold_valid_r;
    hold_sym_nxt    = hold_sym_r;
    hold_status_nxt = hold_status_r;
    out_valid_nxt   = out_valid_r;
    out_sym_nxt     = out_sym_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = clr_r;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    new_res         = 1'b0;
    new_sym         = '0;
    new_status      = hufd_pkg::STS_SYMBOL;
    stall           = 1'b0;
    end_take        = 1'b0;
    ovf_take        = 1'b0;

    // output register drains on its own
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      hufd_pkg::ST_CLEAR: begin
        // write every entry as unused with a zero symbol
        ram_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = hufd_pkg::ST_IDLE;
        end
      end

      hufd_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.command)
            hufd_pkg::CMD_LOAD: begin
              if (load_in_range) begin
                ram_we    = 1'b1;
                ram_waddr = hufd_pkg::tbl_idx_t'(in_chan.entry_index);
                ram_wdata = hufd_pkg::entry_t'{
                  used: in_chan.entry_used,
                  sym:  hufd_pkg::tsym_t'(in_chan.entry_symbol)
                };
              end
            end
            hufd_pkg::CMD_DECODE: begin
              // a byte after end of stream is dropped
              if (!done_r) begin
                sh_nxt     = in_chan.data_byte;
                bitcnt_nxt = '0;
                pend_nxt   = 1'b0;
                state_nxt  = hufd_pkg::ST_BITS;
              end
            end
            hufd_pkg::CMD_RESTART: begin
              walk_nxt = '0;
              done_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end

      hufd_pkg::ST_BITS, hufd_pkg::ST_TAIL: begin
        if (leaf) begin
          new_res = 1'b1;
          if (end_match) begin
            new_status = hufd_pkg::STS_END;
          end else begin
            new_sym    = hufd_pkg::sym_t'(ram_rdata.sym);
            new_status = hufd_pkg::STS_SYMBOL;
          end
        end else if (state_r == hufd_pkg::ST_BITS && overflow) begin
          new_res    = 1'b1;
          new_status = hufd_pkg::STS_OVERFLOW;
        end

        // a second result needs the output register free
        stall = new_res && hold_valid_r && !out_free;

        if (!stall) begin
          if (new_res) begin
            if (hold_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_sym_nxt    = hold_sym_r;
              out_status_nxt = hold_status_r;
              out_last_nxt   = 1'b0;
            end
            hold_valid_nxt  = 1'b1;
            hold_sym_nxt    = new_sym;
            hold_status_nxt = new_status;
          end

          if (leaf && end_match) begin
            // end of stream: rest of the byte is dropped
            end_take  = 1'b1;
            done_nxt  = 1'b1;
            walk_nxt  = '0;
            pend_nxt  = 1'b0;
            state_nxt = hufd_pkg::ST_FLUSH;
          end else if (state_r == hufd_pkg::ST_TAIL) begin
            // partial code carries over to the next byte
            walk_nxt  = base_idx;
            pend_nxt  = 1'b0;
            state_nxt = hufd_pkg::ST_FLUSH;
          end else if (overflow) begin
            ovf_take  = 1'b1;
            walk_nxt  = '0;
            pend_nxt  = 1'b0;
            state_nxt = hufd_pkg::ST_FLUSH;
          end else begin
            ram_re     = 1'b1;
            walk_nxt   = next_idx[hufd_pkg::TBL_AW-1:0];
            pend_nxt   = 1'b1;
            bitcnt_nxt = bitcnt_r + 1'b1;
            sh_nxt     = msb_first_r ? {sh_r[hufd_pkg::BYTE_W-2:0], 1'b0}
                                     : {1'b0, sh_r[hufd_pkg::BYTE_W-1:1]};
            if (&bitcnt_r) begin
              state_nxt = hufd_pkg::ST_TAIL;
            end
          end
        end
      end

      hufd_pkg::ST_FLUSH: begin
        // the held item is the last one of this byte
        if (hold_valid_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_sym_nxt    = hold_sym_r;
            out_status_nxt = hold_status_r;
            out_last_nxt   = 1'b1;
            hold_valid_nxt = 1'b0;
            state_nxt      = hufd_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = hufd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = hufd_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hufd_pkg::ST_CLEAR;
      clr_r        <= '0;
      walk_r       <= '0;
      pend_r       <= 1'b0;
      done_r       <= 1'b0;
      bitcnt_r     <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      walk_r       <= walk_nxt;
      pend_r       <= pend_nxt;
      done_r       <= done_nxt;
      bitcnt_r     <= bitcnt_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sh_r          <= sh_nxt;
    hold_sym_r    <= hold_sym_nxt;
    hold_status_r <= hold_status_nxt;
    out_sym_r     <= out_sym_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  // a new item is taken only with the hold stage empty
  `HUFD_ASSERT_NOW(a_ready_hold_empty, clk, rst_n, in_chan.ready, !hold_valid_r)
  // table writes only from the clearing pass or a load
  `HUFD_ASSERT_NOW(a_write_when_idle, clk, rst_n, ram_we,
    (state_r == hufd_pkg::ST_IDLE) || (state_r == hufd_pkg::ST_CLEAR))
  // end symbol taken marks the stream done
  `HUFD_ASSERT_NXT(a_end_sets_done, clk, rst_n, end_take,
    done_r && (state_r == hufd_pkg::ST_FLUSH))
  // overflow sends the walk back to the root
  `HUFD_ASSERT_NXT(a_ovf_root, clk, rst_n, ovf_take, (walk_r == '0) && !pend_r)

endmodule

>>> verif/huffman_tree_table_decoder_tb.sv
// self-checking testbench for the huffman tree table decoder
// depends on hufd_pkg, hufd_in_if, hufd_out_if and the decoder rtl
`timescale 1ns / 1ps

module huffman_tree_table_decoder_tb;

  // command code the block must ignore
  localparam logic [hufd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  // idle cycles before a register write, enough for a decode with no result to finish
  localparam int SETTLE_CYCLES = 24;
  // stop the random part once this many items have had an effect
  localparam int ITEM_TARGET   = 300;
  // hard stop, far above the slowest passing run
  localparam longint RUN_LIMIT_NS = 64'd5_000_000;

  typedef struct packed {
    logic [hufd_pkg::CMD_W-1:0]  command;
    logic [hufd_pkg::IDX_W-1:0]  entry_index;
    logic                        entry_used;
    hufd_pkg::sym_t              entry_symbol;
    logic [hufd_pkg::BYTE_W-1:0] data_byte;
  } code_item_t;

  typedef struct packed {
    hufd_pkg::sym_t    symbol;
    hufd_pkg::status_t status;
    logic              last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  // configuration port
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [hufd_pkg::APB_AW-1:0] paddr;
  logic [hufd_pkg::APB_DW-1:0] pwdata;
  logic [hufd_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  hufd_in_if  in_chan ();
  hufd_out_if out_chan ();

  huffman_tree_table_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // predicted decoder state: code tree table, walk position, stream flag and
  // the two register values as last written
  // -------------------------------------------------------------------------
  logic           tbl_used [hufd_pkg::TABLE_SIZE];
  hufd_pkg::sym_t tbl_sym  [hufd_pkg::TABLE_SIZE];
  int unsigned    walk_pos;
  bit             stream_ended;
  hufd_pkg::sym_t end_sym_cfg;
  bit             msb_first_cfg;

  result_t expected_symbols [$];
  int      mismatches;
  int      items_applied;    // items that changed state or decoded bits

  // idling control: a quiet side never waits
  bit quiet_in;
  bit quiet_out;

  // walk the tree for one accepted item and queue the results it causes
  task automatic predict_symbols(input code_item_t it);
    result_t     batch [8];
    int          n;
    int unsigned nxt;
    int unsigned code_bit;
    n = 0;
    case (it.command)
      hufd_pkg::CMD_LOAD: begin
        // 13-bit index is always inside the 8192-entry table
        tbl_used[it.entry_index] = it.entry_used;
        tbl_sym[it.entry_index]  = it.entry_symbol;
        items_applied++;
      end
      hufd_pkg::CMD_RESTART: begin
        walk_pos     = 0;
        stream_ended = 1'b0;
        items_applied++;
      end
      hufd_pkg::CMD_DECODE: begin
        // bytes after the end symbol are dropped until a restart
        if (!stream_ended) begin
          items_applied++;
          for (int j = 0; j < hufd_pkg::BYTE_W; j++) begin
            code_bit = msb_first_cfg ? 32'(it.data_byte[hufd_pkg::BYTE_W-1-j])
                                     : 32'(it.data_byte[j]);
            nxt      = 2 * walk_pos + 1 + code_bit;
            if (nxt >= hufd_pkg::TABLE_SIZE) begin
              // ran off the table: flag it, drop the rest of the byte
              batch[n] = '{symbol: '0, status: hufd_pkg::STS_OVERFLOW, last: 1'b0};
              n++;
              walk_pos = 0;
              break;
            end
            walk_pos = nxt;
            if (tbl_used[nxt]) begin
              walk_pos = 0;
              if (tbl_sym[nxt] == end_sym_cfg) begin
                batch[n] = '{symbol: '0, status: hufd_pkg::STS_END, last: 1'b0};
                n++;
                stream_ended = 1'b1;
                break;
              end
              batch[n] = '{symbol: tbl_sym[nxt], status: hufd_pkg::STS_SYMBOL,
                           last: 1'b0};
              n++;
            end
          end
        end
      end
      default: ;  // unused command code does nothing
    endcase
    for (int k = 0; k < n; k++) begin
      batch[k].last = (k == n - 1);
      expected_symbols.push_back(batch[k]);
    end
  endtask

  // -------------------------------------------------------------------------
  // input side: one item per call, valid kept high across back-to-back items;
  // ready is looked at mid-cycle so the edge that takes the item is known
  // -------------------------------------------------------------------------
  task automatic send_item(input code_item_t it);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.command      <= it.command;
    in_chan.entry_index  <= it.entry_index;
    in_chan.entry_used   <= it.entry_used;
    in_chan.entry_symbol <= it.entry_symbol;
    in_chan.data_byte    <= it.data_byte;
    @(negedge clk);
    while (!in_chan.ready) @(negedge clk);
    @(posedge clk);
    predict_symbols(it);
  endtask

  // fields that the command does not use carry random bits
  function automatic code_item_t random_item(input logic [hufd_pkg::CMD_W-1:0] cmd);
    code_item_t it;
    it.command      = cmd;
    it.entry_index  = hufd_pkg::IDX_W'($urandom_range(0, hufd_pkg::TABLE_SIZE - 1));
    it.entry_used   = 1'($urandom_range(0, 1));
    it.entry_symbol = hufd_pkg::SYM_W'($urandom_range(0, 511));
    it.data_byte    = hufd_pkg::BYTE_W'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic load_entry(input int unsigned idx, input logic used, input int unsigned sym);
    code_item_t it;
    it              = random_item(hufd_pkg::CMD_LOAD);
    it.entry_index  = hufd_pkg::IDX_W'(idx);
    it.entry_used   = used;
    it.entry_symbol = hufd_pkg::SYM_W'(sym);
    send_item(it);
  endtask

  task automatic decode_byte(input logic [hufd_pkg::BYTE_W-1:0] data);
    code_item_t it;
    it           = random_item(hufd_pkg::CMD_DECODE);
    it.data_byte = data;
    send_item(it);
  endtask

  task automatic send_command(input logic [hufd_pkg::CMD_W-1:0] cmd);
    send_item(random_item(cmd));
  endtask

  // drop valid, wait for every queued result, then let a result-free decode
  // finish so that a register write lands while the block is idle
  task automatic finish_phase();
    in_chan.valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup phase, access phase held until pready, then an idle phase
  task automatic reg_write(input logic [0:0] sel, input logic [hufd_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (sel == hufd_pkg::REG_END_SYMBOL) begin
      end_sym_cfg = value[hufd_pkg::SYM_W-1:0];
    end else begin
      msb_first_cfg = value[0];
    end
  endtask

  // grow a random prefix code from the root; internal nodes are written as
  // unused so old leaves cannot cut a walk short, a few nodes are left
  // unwritten so stale entries and overflows still show up
  task automatic plant_tree(input int depth_cap, input bit skinny);
    int unsigned open_nodes  [$];
    int          open_depths [$];
    int unsigned node;
    int          node_depth;
    int          leaves;
    int          pick;
    int unsigned leaf_sym;
    bit          make_leaf;
    leaves = 0;
    load_entry(0, 1'b0, $urandom_range(0, 511));
    open_nodes  = '{1, 2};
    open_depths = '{1, 1};
    while (open_nodes.size() != 0) begin
      node       = open_nodes.pop_front();
      node_depth = open_depths.pop_front();
      if ($urandom_range(0, 15) == 0) begin
        continue;
      end
      if (skinny) begin
        make_leaf = (node_depth >= depth_cap) || (node % 2 == 0);
      end else begin
        make_leaf = (node_depth >= depth_cap) || ($urandom_range(0, 2) == 0) ||
                    (leaves + open_nodes.size() >= 14);
      end
      if (make_leaf) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       leaf_sym = 32'(end_sym_cfg);
          1:       leaf_sym = 0;
          2:       leaf_sym = 511;
          default: leaf_sym = $urandom_range(0, 511);
        endcase
        load_entry(node, 1'b1, leaf_sym);
        leaves++;
      end else begin
        load_entry(node, 1'b0, $urandom_range(0, 511));
        open_nodes.push_back(2 * node + 1);
        open_nodes.push_back(2 * node + 2);
        open_depths.push_back(node_depth + 1);
        open_depths.push_back(node_depth + 1);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // directed tests
  // -------------------------------------------------------------------------

  // empty table: all ones walks the right edge and overflows on the 13th bit
  task automatic test_empty_table_overflow();
    decode_byte(8'hFF);
    decode_byte(8'hFF);
    decode_byte(8'hAA);
  endtask

  // all zeros reaches index 8191, the one depth-13 slot inside the table
  task automatic test_deepest_code();
    send_command(hufd_pkg::CMD_RESTART);
    load_entry(hufd_pkg::TABLE_SIZE - 1, 1'b1, 511);
    decode_byte(8'h00);
    decode_byte(8'h00);
    load_entry(hufd_pkg::TABLE_SIZE - 1, 1'b0, 0);
    send_command(hufd_pkg::CMD_RESTART);
  endtask

  // code: 0 -> 0, 10 -> 511, 11 -> end symbol (256)
  task automatic test_small_tree();
    load_entry(0, 1'b0, 0);
    load_entry(1, 1'b1, 0);
    load_entry(2, 1'b0, 511);
    load_entry(5, 1'b1, 511);
    load_entry(6, 1'b1, 32'(hufd_pkg::END_SYMBOL_RST));
    decode_byte(8'h46);               // several symbols, then end mid-byte
    decode_byte(8'h00);               // dropped: stream has ended
    send_command(CMD_UNUSED);         // no effect at all
    send_command(hufd_pkg::CMD_RESTART);
    decode_byte(8'h00);               // eight results from one byte
    decode_byte(8'h01);               // byte ends inside a code
    decode_byte(8'h00);               // the code completes as 511
    decode_byte(8'hFF);               // end symbol on the first code
    send_command(hufd_pkg::CMD_RESTART);
  endtask

  // same tree with bits taken least significant first
  task automatic test_lsb_first();
    finish_phase();
    reg_write(hufd_pkg::REG_MSB_FIRST, 32'd0);
    decode_byte(8'h02);
    decode_byte(8'hC0);
    send_command(hufd_pkg::CMD_RESTART);
    finish_phase();
    reg_write(hufd_pkg::REG_MSB_FIRST, 32'd1);
  endtask

  // end symbol at both ends of its range, matching leaves of the small tree
  task automatic test_end_symbol_extremes();
    finish_phase();
    reg_write(hufd_pkg::REG_END_SYMBOL, 32'd0);
    decode_byte(8'h00);
    send_command(hufd_pkg::CMD_RESTART);
    finish_phase();
    reg_write(hufd_pkg::REG_END_SYMBOL, 32'd511);
    decode_byte(8'h5F);
    send_command(hufd_pkg::CMD_RESTART);
  endtask

  // -------------------------------------------------------------------------
  // random streams: each phase sets the registers, plants a fresh tree and
  // feeds mostly decode bytes, with restarts, stray loads and unused codes
  // -------------------------------------------------------------------------
  task automatic test_random_streams();
    int phase;
    int pick;
    int unsigned end_sym;
    phase = 0;
    while (items_applied < ITEM_TARGET) begin
      finish_phase();
      case (phase % 4)
        0:       end_sym = 0;
        1:       end_sym = 511;
        default: end_sym = $urandom_range(0, 511);
      endcase
      reg_write(hufd_pkg::REG_END_SYMBOL, end_sym);
      reg_write(hufd_pkg::REG_MSB_FIRST, (phase < 2) ? phase % 2 : $urandom_range(0, 1));
      quiet_in = ($urandom_range(0, 3) == 0);
      plant_tree(($urandom_range(0, 3) == 0) ? 12 : $urandom_range(2, 6),
                 $urandom_range(0, 4) == 0);
      send_command(hufd_pkg::CMD_RESTART);
      repeat (40) begin
        pick = $urandom_range(0, 99);
        if (stream_ended && $urandom_range(0, 3) != 0) begin
          send_command(hufd_pkg::CMD_RESTART);
        end else if (pick < 82) begin
          decode_byte(hufd_pkg::BYTE_W'($urandom_range(0, 255)));
        end else if (pick < 88) begin
          send_command(hufd_pkg::CMD_RESTART);
        end else if (pick < 95) begin
          load_entry($urandom_range(0, hufd_pkg::TABLE_SIZE - 1), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 511));
        end else begin
          send_command(CMD_UNUSED);
        end
      end
      phase++;
    end
  endtask

  // -------------------------------------------------------------------------
  // result side: ready stalls drawn per item, quiet stretches toggle now and then
  // -------------------------------------------------------------------------
  initial begin : result_ready
    int stall;
    out_chan.ready <= 1'b0;
    quiet_out = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) quiet_out = !quiet_out;
      stall = quiet_out ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(negedge clk);
      while (!out_chan.valid) @(negedge clk);
      @(posedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_symbols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result, symbol %0d sts %0d last %0b", $time,
                   out_chan.symbol, out_chan.status, out_chan.last);
        end
      end else begin
        want = expected_symbols.pop_front();
        if (out_chan.symbol !== want.symbol || out_chan.status !== want.status ||
            out_chan.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"%0t: result mismatch, symbol exp %0d got %0d, ",
                      "sts exp %0d got %0d, last exp %0b got %0b"},
                     $time, want.symbol, out_chan.symbol, want.status, out_chan.status,
                     want.last, out_chan.last);
          end
        end
      end
    end
  end

  // hard stop in case the block hangs
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin : main_sequence
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.command      <= hufd_pkg::CMD_LOAD;
    in_chan.entry_index  <= '0;
    in_chan.entry_used   <= 1'b0;
    in_chan.entry_symbol <= '0;
    in_chan.data_byte    <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;

    // state after reset: empty table, default registers
    foreach (tbl_used[k]) begin
      tbl_used[k] = 1'b0;
      tbl_sym[k]  = '0;
    end
    walk_pos      = 0;
    stream_ended  = 1'b0;
    end_sym_cfg   = hufd_pkg::END_SYMBOL_RST;
    msb_first_cfg = 1'b1;
    mismatches    = 0;
    items_applied = 0;
    quiet_in      = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // the block clears its table first; the first item simply waits for ready
    test_empty_table_overflow();
    test_deepest_code();
    test_small_tree();
    test_lsb_first();
    test_end_symbol_extremes();
    test_random_streams();
    finish_phase();

    if (mismatches == 0 && expected_symbols.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
